// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_PROP(label, clock, reset_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) prop) \
		else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, clock, reset_n, cond, msg) \
	label: assert property (@(posedge clock) disable iff (!reset_n) !(cond)) \
		else $error(msg);

`else

`define ASSERT_PROP(label, clock, reset_n, prop, msg)
`define ASSERT_NEVER(label, clock, reset_n, cond, msg)

`endif

`endif

// File: sv/bhc_pkg.sv
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared types and constants of the byte histogram counter.
// ----------------------------------------------------------------------------
package bhc_pkg;

	// bin memory geometry
	localparam int NUM_BINS   = 256;
	localparam int IDX_BITS   = $clog2(NUM_BINS);
	localparam int COUNT_BITS = 32;
	localparam int OUT_BITS   = 32;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [OUT_BITS-1:0]   out_count_t;

	// command codes
	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	// clamp a held count to the output width
	function automatic out_count_t sat_out(input count_t c);
		logic [63:0] wide;
		wide = 64'(c);
		if (wide > 64'({OUT_BITS{1'b1}}))
			sat_out = '1;
		else
			sat_out = wide[OUT_BITS-1:0];
	endfunction

endpackage

// File: sv/byte_histogram_counter.sv
// ----------------------------------------------------------------------------
// byte_histogram_counter
// 256-bin byte frequency histogram with saturating counts, a running
// maximum, bin read-out and a clear of all bins at once.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-------------------------------------
//  cmd      | in  | cmd_valid/cmd_stall  | command, byte_value
//  rsp      | out | rsp_valid/rsp_stall  | bin_count, max_count, bin_reported
//  cfg      | in  | cfg_wen              | cfg_wdata (include_zero)
//
//  One word per cycle sustained while cmd_stall is low; in stage 1 the bin
//  memory read (issued at acceptance) returns and the updated count is
//  written back. The last write is forwarded so repeated bins need no bubble.
//  A read result passes from stage 1 into the output register.
//  Reset and the clear command empty all bins at once through per-bin valid
//  bits, so there is no clearing pass. cmd_stall rises only when a read waits
//  in stage 1 behind a full, stalled output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_histogram_counter
	import bhc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wen,
	input  logic                cfg_wdata,
	// command channel
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic [1:0]          command,
	input  logic [7:0]          byte_value,
	// response channel
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [OUT_BITS-1:0] bin_count,
	output logic [OUT_BITS-1:0] max_count,
	output logic                bin_reported
);

	// state
	count_t                 mem [NUM_BINS];
	count_t                 rd_data_q;
	logic [NUM_BINS-1:0]    bin_vld_q;
	count_t                 max_q;
	logic                   include_zero_q;

	logic                   valid_s1;
	cmd_t                   cmd_s1;
	idx_t                   idx_s1;

	logic                   wr_vld_q;
	idx_t                   wr_idx_q;
	count_t                 wr_data_q;

	logic                   rsp_valid_q;
	out_count_t             bin_count_q;
	out_count_t             max_count_q;
	logic                   bin_reported_q;

	logic                   accept;
	logic                   adv_s1;
	logic                   is_read_s1;
	logic                   is_clear_s1;
	logic                   add_en_s1;
	logic                   fwd_hit;
	count_t                 old_count;
	count_t                 new_count;
	idx_t                   idx_in;

	assign idx_in = byte_value[IDX_BITS-1:0];

	// stage 1 control
	always_comb begin
		is_read_s1  = valid_s1 && (cmd_s1 == CMD_READ);
		is_clear_s1 = valid_s1 && (cmd_s1 == CMD_CLEAR);
		adv_s1      = valid_s1 && !(is_read_s1 && rsp_valid_q && rsp_stall);
		add_en_s1   = adv_s1 && (cmd_s1 == CMD_ADD) &&
			((idx_s1 != '0) || include_zero_q);
		cmd_stall   = valid_s1 && !adv_s1;
		accept      = cmd_valid && !cmd_stall;
	end

	// current count of the bin in stage 1, with forwarding of the last write
	always_comb begin
		fwd_hit = wr_vld_q && (wr_idx_q == idx_s1);
		if (fwd_hit)
			old_count = wr_data_q;
		else if (bin_vld_q[idx_s1])
			old_count = rd_data_q;
		else
			old_count = '0;
		new_count = (old_count == '1) ? old_count : old_count + count_t'(1);
	end

	// bin memory: read at acceptance, write back from stage 1
	always_ff @(posedge clk) begin
		if (add_en_s1)
			mem[idx_s1] <= new_count;
		if (accept)
			rd_data_q <= mem[idx_in];
	end

	// stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cmd_s1   <= CMD_ADD;
			idx_s1   <= '0;
		end else if (!cmd_stall) begin
			valid_s1 <= accept;
			if (accept) begin
				cmd_s1 <= cmd_t'(command);
				idx_s1 <= idx_in;
			end
		end
	end

	// bin valid bits, running maximum and last-write forwarding register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			max_q     <= '0;
			wr_vld_q  <= 1'b0;
			wr_idx_q  <= '0;
			wr_data_q <= '0;
		end else if (is_clear_s1) begin
			bin_vld_q <= '0;
			max_q     <= '0;
			wr_vld_q  <= 1'b0;
		end else if (add_en_s1) begin
			bin_vld_q[idx_s1] <= 1'b1;
			wr_vld_q          <= 1'b1;
			wr_idx_q          <= idx_s1;
			wr_data_q         <= new_count;
			if (new_count > max_q)
				max_q <= new_count;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			include_zero_q <= 1'b0;
		else if (cfg_wen)
			include_zero_q <= cfg_wdata;
	end

	// response output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (is_read_s1 && adv_s1)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (is_read_s1 && adv_s1) begin
			bin_count_q    <= sat_out(old_count);
			max_count_q    <= sat_out(max_q);
			bin_reported_q <= (old_count != '0) || include_zero_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign bin_count    = bin_count_q;
	assign max_count    = max_count_q;
	assign bin_reported = bin_reported_q;

	// checks
	`ASSERT_PROP(a_rsp_from_read, clk, arst_n,
		$rose(rsp_valid) |-> $past(is_read_s1 && adv_s1),
		"response raised without a read word in stage 1")
	`ASSERT_PROP(a_max_covers_write, clk, arst_n,
		wr_vld_q |-> (max_q >= wr_data_q),
		"running maximum below the last written count")
	`ASSERT_PROP(a_clear_zeroes_max, clk, arst_n,
		is_clear_s1 |=> (max_q == '0) && !wr_vld_q && (bin_vld_q == '0),
		"clear did not empty the bins and maximum")
	`ASSERT_PROP(a_stalled_read_holds, clk, arst_n,
		cmd_stall |=> valid_s1 && (cmd_s1 == CMD_READ) && $stable(idx_s1),
		"stalled read word in stage 1 changed")

endmodule
